[src/fir_lp_pkg.sv]
// Shared types and constants of the low-pass FIR filter.
// Holds the coefficient table, the controller state type and the command and
// status structs between controller and datapath. No dependencies.
`default_nettype none

package fir_lp_pkg;

  // Coefficients are unsigned Q0.15 held in 12 bits (values below 0.125)
  localparam int unsigned COEFF_FRAC_BITS = 15;
  localparam int unsigned COEF_W          = 12;
  localparam int unsigned COEF_LEN        = 17;

  localparam logic [COEF_W-1:0] COEF_TABLE [COEF_LEN] = '{
    12'd290,  12'd421,  12'd794,  12'd1355, 12'd2022, 12'd2694,
    12'd3266, 12'd3650, 12'd3785, 12'd3650, 12'd3266, 12'd2694,
    12'd2022, 12'd1355, 12'd794,  12'd421,  12'd290
  };

  // Input operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Taps past the end of the table weigh zero
  function automatic logic [COEF_W-1:0] coef_at(input logic [7:0] k);
    logic [COEF_W-1:0] c;
    c = '0;
    if (k < 8'(COEF_LEN)) begin
      c = COEF_TABLE[k[4:0]];
    end
    return c;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MAC   = 3'b010,
    ST_DRAIN = 3'b100
  } fsm_state_e;

  typedef struct packed {
    logic accept_smp;  // write sample into ring, start a new sum
    logic clear;       // drop history, pointer to zero
    logic rd_en;       // issue one tap read
    logic out_ld;      // load rounded result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic busy;        // tap reads still in the MAC pipeline
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[src/fir_lp_ctrl.sv]
// Controller of the low-pass FIR filter: input handshake and tap sequencing.
// Depends on fir_lp_pkg.
`default_nettype none

module fir_lp_ctrl
  import fir_lp_pkg::*;
#(
  parameter int unsigned TAPS  = 17,
  parameter int unsigned TAP_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire dp_status_t       status_i,
  output dp_cmd_t               cmd_o,
  output logic [TAP_W-1:0]      tap_o
);

  fsm_state_e       state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign tap_o      = tap_q;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.accept_smp = 1'b1;
            tap_d            = '0;
            state_d          = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.rd_en = 1'b1;
        if (tap_q == TAP_W'(TAPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy && status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

endmodule

`default_nettype wire

[src/fir_lp_dp.sv]
// Datapath of the low-pass FIR filter: sample ring, shared MAC pipeline,
// rounding, saturation and output register. Depends on fir_lp_pkg.
`default_nettype none

module fir_lp_dp
  import fir_lp_pkg::*;
#(
  parameter int unsigned TAPS         = 17,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TAP_W        = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dp_cmd_t                        cmd_i,
  input  wire logic        [TAP_W-1:0]        tap_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output dp_status_t                          status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      filtered_o
);

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_W + 1;
  localparam int unsigned ACC_W  = PROD_W + TAP_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN  =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  // Ring storage; entries not written since the last clear read as zero
  logic signed [SAMPLE_WIDTH-1:0] ring_mem [TAPS];
  logic [TAPS-1:0]                vld_q;
  logic [TAP_W-1:0]               wp_q;
  logic [TAP_W-1:0]               rd_idx_q;

  // MAC pipeline
  logic                           s1_q, s2_q;
  logic signed [SAMPLE_WIDTH-1:0] rd_data_q;
  logic                           rd_vld_q;
  logic [COEF_W-1:0]              coef_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;

  logic signed [SAMPLE_WIDTH-1:0] tap_smp;
  logic signed [ACC_W-1:0]        rnd_sum, shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] filtered_q;

  function automatic logic [TAP_W-1:0] idx_inc(input logic [TAP_W-1:0] i);
    return (i == TAP_W'(TAPS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [TAP_W-1:0] idx_dec(input logic [TAP_W-1:0] i);
    return (i == '0) ? TAP_W'(TAPS - 1) : i - 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_smp) begin
      ring_mem[wp_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= ring_mem[rd_idx_q];
      rd_vld_q  <= vld_q[rd_idx_q];
      coef_q    <= coef_at(8'(tap_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wp_q     <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        vld_q <= '0;
        wp_q  <= '0;
      end else if (cmd_i.accept_smp) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= idx_inc(wp_q);
        rd_idx_q    <= wp_q;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= idx_dec(rd_idx_q);
      end
    end
  end

  assign tap_smp = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_q <= PROD_W'(tap_smp) * $signed({1'b0, coef_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_smp) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= cmd_i.rd_en;
      s2_q <= s1_q;
    end
  end

  // Round half up, drop fraction, clamp to sample range
  assign rnd_sum = acc_q + RND_HALF;
  assign shifted = rnd_sum >>> COEFF_FRAC_BITS;

  always_comb begin
    priority if (shifted > SAT_MAX) begin
      sat_val = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_MIN) begin
      sat_val = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      filtered_q <= sat_val;
    end
  end

  assign status_o.busy     = s1_q | s2_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

`default_nettype wire

[src/fir_lowpass_ring_buffer.sv]
// Low-pass FIR filter over a ring of past samples, top level.
// Usage:
//   Input channel (in_valid_i / in_stall_o, op_i, sample_i): op_i = filter
//   writes sample_i as the newest sample and produces one filtered result;
//   op_i = clear empties the history and resets the write pointer, no result.
//   Output channel (out_valid_o / out_stall_i, filtered_o): one transaction
//   per filter item, rounded half up and saturated to SAMPLE_WIDTH bits.
// Sequencing:
//   A filter item runs through one shared multiply-accumulate, one tap per
//   cycle, in ST_MAC; ST_DRAIN then waits until the MAC pipeline is empty
//   and the output register is free, loads the result and returns to ST_IDLE,
//   and only then is the next item taken. A clear is handled in ST_IDLE.
//   in_stall_o is high while an item is in the MAC loop or waits in ST_DRAIN.
// Reset: history reads as zero, write pointer zero, no result pending.
// Output stall: the output register holds its result; a finished sum waits
//   in the accumulator until the register frees, and input stays stalled.
// Depends on fir_lp_pkg, fir_lp_ctrl, fir_lp_dp.
`default_nettype none

module fir_lowpass_ring_buffer
  import fir_lp_pkg::*;
#(
  parameter int unsigned TAPS         = 17,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           op_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      filtered_o
);

  localparam int unsigned TAP_W = $clog2(TAPS);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [TAP_W-1:0] tap;

  fir_lp_ctrl #(
    .TAPS  (TAPS),
    .TAP_W (TAP_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .tap_o      (tap)
  );

  fir_lp_dp #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TAP_W        (TAP_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .tap_i       (tap),
    .sample_i    (sample_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

endmodule

`default_nettype wire

[test/fir_lp_checker.sv]
// Checker for the low-pass FIR filter: watches both channels, keeps its own
// copy of the sample ring and predicts every filtered result, then compares.
// Depends on fir_lp_pkg for the operation codes.
module fir_lp_checker
  import fir_lp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               op_i,
  input  logic signed [15:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] filtered_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS     = 17;
  localparam int FRAC_BITS = 15;
  localparam longint MAX_OUT = 32767;
  localparam longint MIN_OUT = -32768;

  // Q1.15 weights of the symmetric low-pass design
  localparam int WEIGHTS [NTAPS] = '{
    290, 421, 794, 1355, 2022, 2694, 3266, 3650, 3785,
    3650, 3266, 2694, 2022, 1355, 794, 421, 290
  };

  logic signed [15:0] ring [NTAPS];
  logic [4:0]         wr_ptr;
  logic signed [15:0] expected_filtered [$];

  int n_errors    = 0;
  int n_pending   = 0;
  int n_checked   = 0;
  int n_saturated = 0;

  assign errors_o    = n_errors;
  assign pending_o   = n_pending;
  assign checked_o   = n_checked;
  assign saturated_o = n_saturated;

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    n_errors++;
    $display("%0t checker: %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic clear_history();
    foreach (ring[i]) ring[i] = '0;
    wr_ptr = '0;
  endtask

  // newest sample goes in at the pointer, the sum runs backwards in time
  task automatic filter_sample(input logic signed [15:0] smp);
    longint acc;
    longint q;
    int     idx;
    ring[wr_ptr] = smp;
    idx = wr_ptr;
    acc = 0;
    for (int k = 0; k < NTAPS; k++) begin
      acc += longint'(ring[idx]) * longint'(WEIGHTS[k]);
      idx = (idx == 0) ? NTAPS - 1 : idx - 1;
    end
    wr_ptr = (wr_ptr == 5'(NTAPS - 1)) ? '0 : wr_ptr + 5'd1;
    q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > MAX_OUT || q < MIN_OUT) begin
      n_saturated++;
    end
    if (q > MAX_OUT) q = MAX_OUT;
    if (q < MIN_OUT) q = MIN_OUT;
    expected_filtered.push_back(16'(q));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      clear_history();
      expected_filtered.delete();
    end else begin
      // results first: nothing taken this edge can already be on the output
      if (out_valid_i && !out_stall_i) begin
        if (expected_filtered.size() == 0) begin
          report_mismatch("result with no sample waiting", filtered_i, 'x);
        end else begin
          want = expected_filtered.pop_front();
          n_checked++;
          if (filtered_i !== want) begin
            report_mismatch("filtered value", filtered_i, want);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_CLEAR) begin
          clear_history();
        end else begin
          filter_sample(sample_i);
        end
      end
    end
    n_pending = expected_filtered.size();
  end

endmodule

[test/tb_top.sv]
// Top of the low-pass FIR filter testbench: clock, reset, sample stimulus
// with random idling on both channels, watchdog and verdict.
// Depends on fir_lp_pkg, fir_lowpass_ring_buffer and fir_lp_checker.
module tb_top
  import fir_lp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1550;
  localparam int QUIET_TAIL  = 150;
  localparam int STALL_LIMIT = 2000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               op_i        = OP_FILTER;
  logic signed [15:0] sample_i    = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [15:0] filtered_o;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_saturated;

  int n_sent      = 0;
  int n_clears    = 0;
  int idle_odds   = 4;  // one in idle_odds chance of an idle burst, 0 = none
  int stall_left  = 0;
  int idle_cycles = 0;

  always #5ns clk_i = ~clk_i;

  fir_lowpass_ring_buffer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .filtered_o (filtered_o)
  );

  fir_lp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .filtered_i (filtered_o),
    .errors_o   (n_errors),
    .pending_o  (n_pending),
    .checked_o  (n_checked),
    .saturated_o(n_saturated)
  );

  // receiver stalls in bursts of random length
  always @(negedge clk_i) begin
    if (idle_odds == 0) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(1, idle_odds) == 1) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, n_pending);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_item(input logic op, input logic signed [15:0] smp);
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
    if (op == OP_CLEAR) n_clears++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int                 seg_len;
    logic signed [15:0] level;
    bit                 drained_mid;
    drained_mid = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, rounding near zero, clear, full-scale run into saturation
    send_item(OP_CLEAR, 16'sh5a5a);
    send_item(OP_FILTER, 16'sh7fff);
    send_item(OP_FILTER, 16'sh8000);
    send_item(OP_FILTER, 16'sd1);
    send_item(OP_FILTER, -16'sd1);
    send_item(OP_FILTER, 16'sd0);
    send_item(OP_CLEAR, 16'shffff);
    repeat (17) send_item(OP_FILTER, 16'sh7fff);
    send_item(OP_CLEAR, 16'sh0000);
    wait_drained();

    while (n_sent < ITEMS) begin
      if (n_sent > ITEMS - QUIET_TAIL) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 3;
          2: idle_odds = 8;
          default: idle_odds = 20;
        endcase
      end
      if (!drained_mid && n_sent >= ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          seg_len = $urandom_range(8, 60);
          repeat (seg_len) send_item(OP_FILTER, pick_sample());
        end
        5, 6: begin
          // long constant runs fill the ring; a full-scale negative run pushes the sum to its bound
          level = ($urandom_range(0, 1) == 0) ? 16'sh8000 : pick_sample();
          repeat ($urandom_range(17, 26)) send_item(OP_FILTER, level);
        end
        7: begin
          level   = pick_sample();
          seg_len = $urandom_range(10, 30);
          for (int i = 0; i < seg_len; i++) begin
            send_item(OP_FILTER, (i % 2 == 1) ? -level : level);
          end
        end
        8: begin
          send_item(OP_CLEAR, 16'($urandom));
          if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, 16'($urandom));
        end
        default: begin
          // impulse followed by silence walks the whole coefficient set
          send_item(OP_FILTER, pick_sample());
          repeat (17) send_item(OP_FILTER, 16'sd0);
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    idle_odds = 0;
    while (n_pending != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("tb_top: %0d input transactions (%0d clears), %0d filtered results checked",
             n_sent, n_clears, n_checked);
    $display("tb_top: %0d results hit the saturation bounds, %0d mismatches, %0d missing",
             n_saturated, n_errors, n_pending);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[fir_lowpass_ring_buffer.f]
src/fir_lp_pkg.sv
src/fir_lp_ctrl.sv
src/fir_lp_dp.sv
src/fir_lowpass_ring_buffer.sv
test/fir_lp_checker.sv
test/tb_top.sv
